FILE: rtl/pls_pkg.sv
// Package for the positional list store: beat types, opcode and status
// codes, and the control bundle broadcast to the cell chain. No dependencies.
package pls_pkg;

  typedef logic [1:0] shape_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t        opcode;
    logic [4:0] position;
    shape_t     shape_in;
  } req_beat_t;

  typedef struct packed {
    status_t    status;
    shape_t     shape_out;
    logic [4:0] length;
  } rsp_beat_t;

  // Committed update, seen by every cell in the same cycle.
  typedef struct packed {
    logic       ins;
    logic       del;
    logic [4:0] pos;
    shape_t     shape;
  } cell_ctl_t;

endpackage

FILE: rtl/positional_list_store.sv
// Top level of the positional list store: a chain of slot cells, the
// request decoder and the response register. Depends on pls_pkg, pls_cell, pls_ctrl.
//
//  channel | valid     | ready     | payload          | direction
//  --------+-----------+-----------+------------------+----------
//  request | req_valid | req_ready | req (req_beat_t) | in
//  result  | rsp_valid | rsp_ready | rsp (rsp_beat_t) | out
//
// One request beat per cycle; each result appears in the cycle after its request
// is taken, since every cell updates in the same cycle (one shift step of the
// chain per beat). Reset (rst, synchronous) clears the entry count and the
// response valid; slot contents are left as they are. A stalled result holds
// the response register and drops req_ready until it is taken.
module positional_list_store #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  pls_pkg::req_beat_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output pls_pkg::rsp_beat_t rsp
);
  import pls_pkg::*;

  // Only the first 31 slots are reachable by a 5-bit one-based position.
  localparam int RD_TAPS = (CAPACITY < 31) ? CAPACITY : 31;

  logic      fire;
  cell_ctl_t ctl;
  status_t   status;
  logic      rd_ok;
  logic [4:0] length;
  shape_t    rd_shape;
  logic [4:0] rd_idx;
  rsp_beat_t rsp_next;
  shape_t    slot [CAPACITY];

  // Take a beat whenever the response register is free or being emptied.
  assign req_ready = !rsp_valid || rsp_ready;
  assign fire      = req_valid && req_ready;

  pls_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .req    (req),
    .ctl    (ctl),
    .status (status),
    .rd_ok  (rd_ok),
    .length (length)
  );

  // Chain of slots: each cell hands its entry to a neighbor on a shift.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    shape_t left;
    shape_t right;
    if (k == 0) begin : g_head
      assign left = '0;
    end else begin : g_mid_l
      assign left = slot[k-1];
    end
    if (k == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid_r
      assign right = slot[k+1];
    end
    pls_cell #(
      .INDEX (k)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .left  (left),
      .right (right),
      .value (slot[k])
    );
  end

  // Select the addressed slot among the reachable ones.
  assign rd_idx = req.position - 5'd1;

  always_comb begin
    rd_shape = '0;
    for (int k = 0; k < RD_TAPS; k++) begin
      if (rd_idx == 5'(k)) begin
        rd_shape = slot[k];
      end
    end
  end

  always_comb begin
    rsp_next.status    = status;
    rsp_next.shape_out = rd_ok ? rd_shape : '0;
    rsp_next.length    = length;
  end

  // Response register: load on each accepted request, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: rtl/pls_cell.sv
// One list slot of the positional list store chain.
// Depends on pls_pkg for the control bundle and shape type.
module pls_cell #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  pls_pkg::cell_ctl_t ctl,
  input  pls_pkg::shape_t    left,
  input  pls_pkg::shape_t    right,
  output pls_pkg::shape_t    value
);
  import pls_pkg::*;

  localparam logic [31:0] IDX = 32'(INDEX);

  logic [31:0] pos_w;
  shape_t      value_next;

  assign pos_w = 32'(ctl.pos);

  always_comb begin
    value_next = value;
    if (ctl.ins) begin
      if (IDX + 32'd1 == pos_w) begin
        value_next = ctl.shape;
      end else if (IDX >= pos_w) begin
        value_next = left;
      end
    end else if (ctl.del) begin
      if (IDX + 32'd1 >= pos_w) begin
        value_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

FILE: rtl/pls_ctrl.sv
// Request decode, range checks and entry count for the positional list store.
// Depends on pls_pkg for beat types, codes and the cell control bundle.
module pls_ctrl #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  pls_pkg::req_beat_t req,
  output pls_pkg::cell_ctl_t ctl,
  output pls_pkg::status_t   status,
  output logic               rd_ok,
  output logic [4:0]         length
);
  import pls_pkg::*;

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CNTW > 5) ? CNTW : 5) + 1;

  logic [CNTW-1:0] count;
  logic [CNTW-1:0] count_next;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic [CMPW-1:0] len_x;
  logic            pos_zero;
  logic            full;

  assign pos_x    = CMPW'(req.position);
  assign cnt_x    = CMPW'(count);
  assign pos_zero = (req.position == 5'd0);
  assign full     = (count == CNTW'(CAPACITY));

  always_comb begin
    status     = ST_DONE;
    rd_ok      = 1'b0;
    ctl.ins    = 1'b0;
    ctl.del    = 1'b0;
    ctl.pos    = req.position;
    ctl.shape  = req.shape_in;
    count_next = count;
    unique case (req.opcode)
      OP_INSERT: begin
        if (pos_zero || pos_x > cnt_x + CMPW'(1)) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctl.ins    = fire;
          count_next = count + CNTW'(1);
        end
      end
      OP_DELETE: begin
        if (pos_zero || pos_x > cnt_x) begin
          status = ST_RANGE;
        end else begin
          ctl.del    = fire;
          count_next = count - CNTW'(1);
        end
      end
      OP_READ: begin
        if (pos_zero || pos_x > cnt_x) begin
          status = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
        // unused opcode: ignore the request
      end
    endcase
  end

  assign len_x  = CMPW'(count_next);
  assign length = len_x[4:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

endmodule
